/* hw/rtl/dtrk_pkg.sv */
package dtrk_pkg;

  localparam int unsigned MeasWidth   = 16;
  localparam int unsigned WeightWidth = 9;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned AddrWidth   = 3;

  localparam logic [WeightWidth-1:0] WeightOne   = 9'd256;
  localparam logic [WeightWidth-1:0] WeightReset = 9'd154;

  // Register index, taken from the word address.
  localparam logic RegSmoothingWeight = 1'b0;

  typedef logic [MeasWidth-1:0] meas_t;

  typedef struct packed {
    logic  detected;
    logic  shoulder_ok;
    logic  torso_ok;
    meas_t box_center_x;
    meas_t box_center_y;
    meas_t box_width;
    meas_t box_height;
    meas_t shoulder_span;
    meas_t torso_span;
  } item_t;

  typedef struct packed {
    logic                  track_valid;
    logic [CountWidth-1:0] track_number;
    meas_t                 est_center_x;
    meas_t                 est_center_y;
    meas_t                 est_width;
    meas_t                 est_height;
    meas_t                 est_shoulder;
    meas_t                 est_torso;
    logic                  shoulder_fresh;
    logic                  torso_fresh;
  } result_t;

endpackage

/* hw/rtl/dtrk_ema_lane.sv */
module dtrk_ema_lane (
  input  dtrk_pkg::meas_t                     meas,
  input  dtrk_pkg::meas_t                     prev,
  input  logic [dtrk_pkg::WeightWidth-1:0]    weight,
  output dtrk_pkg::meas_t                     est
);

  // w*m + (256-w)*p = 256*p + w*(m-p), so one signed multiply per lane.
  logic signed [dtrk_pkg::MeasWidth:0]                        diff;
  logic signed [dtrk_pkg::WeightWidth:0]                      w_s;
  logic signed [dtrk_pkg::MeasWidth+dtrk_pkg::WeightWidth+1:0] prod;
  logic signed [dtrk_pkg::MeasWidth+dtrk_pkg::WeightWidth+1:0] rounded;
  logic signed [dtrk_pkg::MeasWidth+dtrk_pkg::WeightWidth+1:0] step;

  assign diff    = $signed({1'b0, meas}) - $signed({1'b0, prev});
  assign w_s     = $signed({1'b0, weight});
  assign prod    = w_s * diff;
  assign rounded = prod + 27'sd128;
  assign step    = rounded >>> 8;
  assign est     = prev + step[dtrk_pkg::MeasWidth-1:0];

endmodule

/* hw/rtl/dtrk_cfg.sv */
module dtrk_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtrk_pkg::AddrWidth-1:0]     paddr,
  input  logic [dtrk_pkg::DataWidth-1:0]     pwdata,
  output logic [dtrk_pkg::DataWidth-1:0]     prdata,
  output logic                               pready,
  output logic [dtrk_pkg::WeightWidth-1:0]   weight_eff
);

  logic [dtrk_pkg::WeightWidth-1:0] smoothing_weight;
  logic                             reg_idx;

  assign reg_idx = paddr[dtrk_pkg::AddrWidth-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_weight <= dtrk_pkg::WeightReset;
    end else if (psel && penable && pwrite && reg_idx == dtrk_pkg::RegSmoothingWeight) begin
      smoothing_weight <= pwdata[dtrk_pkg::WeightWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == dtrk_pkg::RegSmoothingWeight) begin
      prdata = {{(dtrk_pkg::DataWidth-dtrk_pkg::WeightWidth){1'b0}}, smoothing_weight};
    end
  end

  // Weights above one saturate to one.
  assign weight_eff = (smoothing_weight > dtrk_pkg::WeightOne) ? dtrk_pkg::WeightOne
                                                               : smoothing_weight;

endmodule

/* hw/rtl/dtrk_update.sv */
module dtrk_update (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fire,
  input  dtrk_pkg::item_t                  item,
  input  logic [dtrk_pkg::WeightWidth-1:0] weight,
  output dtrk_pkg::result_t                result
);

  logic [dtrk_pkg::CountWidth-1:0] track_count, track_count_next;
  logic tracking, tracking_next;
  logic shoulder_seeded, shoulder_seeded_next;
  logic torso_seeded, torso_seeded_next;
  dtrk_pkg::meas_t center_x_est, center_x_est_next;
  dtrk_pkg::meas_t center_y_est, center_y_est_next;
  dtrk_pkg::meas_t width_est, width_est_next;
  dtrk_pkg::meas_t height_est, height_est_next;
  dtrk_pkg::meas_t shoulder_est, shoulder_est_next;
  dtrk_pkg::meas_t torso_est, torso_est_next;

  dtrk_pkg::meas_t ema_cx, ema_cy, ema_w, ema_h, ema_sh, ema_to;
  logic acquire;

  dtrk_ema_lane u_cx (.meas(item.box_center_x),  .prev(center_x_est), .weight(weight), .est(ema_cx));
  dtrk_ema_lane u_cy (.meas(item.box_center_y),  .prev(center_y_est), .weight(weight), .est(ema_cy));
  dtrk_ema_lane u_w  (.meas(item.box_width),     .prev(width_est),    .weight(weight), .est(ema_w));
  dtrk_ema_lane u_h  (.meas(item.box_height),    .prev(height_est),   .weight(weight), .est(ema_h));
  dtrk_ema_lane u_sh (.meas(item.shoulder_span), .prev(shoulder_est), .weight(weight), .est(ema_sh));
  dtrk_ema_lane u_to (.meas(item.torso_span),    .prev(torso_est),    .weight(weight), .est(ema_to));

  assign acquire = item.detected && !tracking;

  always_comb begin
    track_count_next     = track_count;
    tracking_next        = tracking;
    shoulder_seeded_next = shoulder_seeded;
    torso_seeded_next    = torso_seeded;
    center_x_est_next    = center_x_est;
    center_y_est_next    = center_y_est;
    width_est_next       = width_est;
    height_est_next      = height_est;
    shoulder_est_next    = shoulder_est;
    torso_est_next       = torso_est;
    result               = '0;

    if (!item.detected) begin
      tracking_next        = 1'b0;
      shoulder_seeded_next = 1'b0;
      torso_seeded_next    = 1'b0;
      result.track_number  = track_count;
    end else begin
      tracking_next = 1'b1;
      if (acquire) begin
        track_count_next     = track_count + 1'b1;
        center_x_est_next    = item.box_center_x;
        center_y_est_next    = item.box_center_y;
        width_est_next       = '0;
        height_est_next      = '0;
        shoulder_est_next    = '0;
        torso_est_next       = '0;
        shoulder_seeded_next = 1'b0;
        torso_seeded_next    = 1'b0;
      end else begin
        center_x_est_next = ema_cx;
        center_y_est_next = ema_cy;
      end

      // A seeded group cannot be in its acquisition frame, so the lanes
      // can blend against the held estimates directly.
      if (item.shoulder_ok) begin
        width_est_next       = (shoulder_seeded && !acquire) ? ema_w  : item.box_width;
        shoulder_est_next    = (shoulder_seeded && !acquire) ? ema_sh : item.shoulder_span;
        shoulder_seeded_next = 1'b1;
      end
      if (item.torso_ok) begin
        height_est_next   = (torso_seeded && !acquire) ? ema_h  : item.box_height;
        torso_est_next    = (torso_seeded && !acquire) ? ema_to : item.torso_span;
        torso_seeded_next = 1'b1;
      end

      result.track_valid    = shoulder_seeded_next || torso_seeded_next;
      result.track_number   = track_count_next;
      result.est_center_x   = center_x_est_next;
      result.est_center_y   = center_y_est_next;
      result.est_width      = width_est_next;
      result.est_height     = height_est_next;
      result.est_shoulder   = shoulder_est_next;
      result.est_torso      = torso_est_next;
      result.shoulder_fresh = item.shoulder_ok;
      result.torso_fresh    = item.torso_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_count     <= '0;
      tracking        <= 1'b0;
      shoulder_seeded <= 1'b0;
      torso_seeded    <= 1'b0;
      center_x_est    <= '0;
      center_y_est    <= '0;
      width_est       <= '0;
      height_est      <= '0;
      shoulder_est    <= '0;
      torso_est       <= '0;
    end else if (fire) begin
      track_count     <= track_count_next;
      tracking        <= tracking_next;
      shoulder_seeded <= shoulder_seeded_next;
      torso_seeded    <= torso_seeded_next;
      center_x_est    <= center_x_est_next;
      center_y_est    <= center_y_est_next;
      width_est       <= width_est_next;
      height_est      <= height_est_next;
      shoulder_est    <= shoulder_est_next;
      torso_est       <= torso_est_next;
    end
  end

endmodule

/* hw/rtl/detection_ema_tracker.sv */
// An accepted item is held in the input register, and its result is written into the
// result register when that register is empty or being drained (out_stall low).
// Throughput: one item per cycle while out_stall is low; the state update from the
// input register into the result register sets this rate.
// Reset (rst, synchronous, active high) clears the track state and both valid
// registers and sets smoothing_weight to 154.
module detection_ema_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtrk_pkg::AddrWidth-1:0]     paddr,
  input  logic [dtrk_pkg::DataWidth-1:0]     pwdata,
  output logic [dtrk_pkg::DataWidth-1:0]     prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               detected,
  input  logic                               shoulder_ok,
  input  logic                               torso_ok,
  input  logic [15:0]                        box_center_x,
  input  logic [15:0]                        box_center_y,
  input  logic [15:0]                        box_width,
  input  logic [15:0]                        box_height,
  input  logic [15:0]                        shoulder_span,
  input  logic [15:0]                        torso_span,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               track_valid,
  output logic [31:0]                        track_number,
  output logic [15:0]                        est_center_x,
  output logic [15:0]                        est_center_y,
  output logic [15:0]                        est_width,
  output logic [15:0]                        est_height,
  output logic [15:0]                        est_shoulder,
  output logic [15:0]                        est_torso,
  output logic                               shoulder_fresh,
  output logic                               torso_fresh
);

  logic [dtrk_pkg::WeightWidth-1:0] weight_eff;
  logic              item_valid;
  dtrk_pkg::item_t   item;
  dtrk_pkg::result_t result_next;
  dtrk_pkg::result_t result;
  logic advance, fire, in_take;

  dtrk_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .weight_eff(weight_eff)
  );

  // The compute stage moves when the result register is empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign fire     = item_valid && advance;
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_take || (item_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{detected: detected, shoulder_ok: shoulder_ok, torso_ok: torso_ok,
                box_center_x: box_center_x, box_center_y: box_center_y,
                box_width: box_width, box_height: box_height,
                shoulder_span: shoulder_span, torso_span: torso_span};
    end
  end

  dtrk_update u_update (
    .clk(clk), .rst(rst), .fire(fire), .item(item), .weight(weight_eff),
    .result(result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  assign track_valid    = result.track_valid;
  assign track_number   = result.track_number;
  assign est_center_x   = result.est_center_x;
  assign est_center_y   = result.est_center_y;
  assign est_width      = result.est_width;
  assign est_height     = result.est_height;
  assign est_shoulder   = result.est_shoulder;
  assign est_torso      = result.est_torso;
  assign shoulder_fresh = result.shoulder_fresh;
  assign torso_fresh    = result.torso_fresh;

endmodule

/* hw/rtl/dtrk_checker.sv */
module dtrk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        track_valid,
  input logic [31:0] track_number,
  input logic        shoulder_fresh,
  input logic        torso_fresh
);

  // A stalled result keeps its track number.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(track_number))
    else $error("stalled result changed");

  // The input side only backs up behind a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // If out_stall is low once an accepted item sits in the input register, the item
  // moves into the result register and a result is offered.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("result missing after accepted item");

  // A group updated this frame is seeded, so the track is valid.
  a_fresh_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (shoulder_fresh || torso_fresh) |-> track_valid)
    else $error("fresh group without valid track");

endmodule

bind detection_ema_tracker dtrk_checker u_dtrk_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .track_valid(track_valid),
  .track_number(track_number), .shoulder_fresh(shoulder_fresh),
  .torso_fresh(torso_fresh)
);

/* tb/detection_ema_tracker_check.sv */
module detection_ema_tracker_check
  import dtrk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  item_t                frame,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  result_t              track,
  output int unsigned          mismatches,
  output int unsigned          pending
);

  logic [WeightWidth-1:0] weight;
  logic [CountWidth-1:0]  track_seq;
  logic                   locked;
  logic                   width_group_on;
  logic                   height_group_on;
  meas_t                  cx_est, cy_est, width_est, height_est, shoulder_est, torso_est;
  result_t                tracks_due[$];

  // Weights above one behave as one.
  function automatic meas_t blend(meas_t meas, meas_t prev);
    logic [31:0] w;
    logic [31:0] acc;
    w = (weight > WeightOne) ? 32'(WeightOne) : 32'(weight);
    acc = w * 32'(meas) + (32'(WeightOne) - w) * 32'(prev) + 32'd128;
    return acc[23:8];
  endfunction

  task automatic advance_track(input item_t f, output result_t r);
    r = '0;
    if (!f.detected) begin
      locked = 1'b0;
      width_group_on = 1'b0;
      height_group_on = 1'b0;
      r.track_number = track_seq;
      return;
    end
    if (!locked) begin
      track_seq = track_seq + 1'b1;
      cx_est = f.box_center_x;
      cy_est = f.box_center_y;
      width_est = '0;
      height_est = '0;
      shoulder_est = '0;
      torso_est = '0;
      width_group_on = 1'b0;
      height_group_on = 1'b0;
      locked = 1'b1;
    end else begin
      cx_est = blend(f.box_center_x, cx_est);
      cy_est = blend(f.box_center_y, cy_est);
    end
    if (f.shoulder_ok) begin
      width_est = width_group_on ? blend(f.box_width, width_est) : f.box_width;
      shoulder_est = width_group_on ? blend(f.shoulder_span, shoulder_est) : f.shoulder_span;
      width_group_on = 1'b1;
    end
    if (f.torso_ok) begin
      height_est = height_group_on ? blend(f.box_height, height_est) : f.box_height;
      torso_est = height_group_on ? blend(f.torso_span, torso_est) : f.torso_span;
      height_group_on = 1'b1;
    end
    r.track_valid = width_group_on | height_group_on;
    r.track_number = track_seq;
    r.est_center_x = cx_est;
    r.est_center_y = cy_est;
    r.est_width = width_est;
    r.est_height = height_est;
    r.est_shoulder = shoulder_est;
    r.est_torso = torso_est;
    r.shoulder_fresh = f.shoulder_ok;
    r.torso_fresh = f.torso_ok;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      weight = WeightReset;
      track_seq = '0;
      locked = 1'b0;
      width_group_on = 1'b0;
      height_group_on = 1'b0;
      cx_est = '0;
      cy_est = '0;
      width_est = '0;
      height_est = '0;
      shoulder_est = '0;
      torso_est = '0;
      tracks_due.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[AddrWidth-1:2] == RegSmoothingWeight)
        weight = pwdata[WeightWidth-1:0];
      if (in_valid && !in_stall) begin
        advance_track(frame, want);
        tracks_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (tracks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: track result with none outstanding", $realtime);
        end else begin
          want = tracks_due.pop_front();
          check_field("track_valid", 32'(want.track_valid), 32'(track.track_valid));
          check_field("track_number", want.track_number, track.track_number);
          check_field("est_center_x", 32'(want.est_center_x), 32'(track.est_center_x));
          check_field("est_center_y", 32'(want.est_center_y), 32'(track.est_center_y));
          check_field("est_width", 32'(want.est_width), 32'(track.est_width));
          check_field("est_height", 32'(want.est_height), 32'(track.est_height));
          check_field("est_shoulder", 32'(want.est_shoulder), 32'(track.est_shoulder));
          check_field("est_torso", 32'(want.est_torso), 32'(track.est_torso));
          check_field("shoulder_fresh", 32'(want.shoulder_fresh), 32'(track.shoulder_fresh));
          check_field("torso_fresh", 32'(want.torso_fresh), 32'(track.torso_fresh));
        end
      end
      pending <= tracks_due.size();
    end
  end

endmodule

/* tb/detection_ema_tracker_test.sv */
module detection_ema_tracker_test;
  import dtrk_pkg::*;

  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 180;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit  = 2000;
  localparam logic [AddrWidth-1:0] WeightAddr = {RegSmoothingWeight, 2'b00};

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  item_t                frame;
  logic                 out_valid;
  logic                 out_stall;
  logic                 track_valid;
  logic [31:0]          track_number;
  logic [15:0]          est_center_x, est_center_y, est_width, est_height;
  logic [15:0]          est_shoulder, est_torso;
  logic                 shoulder_fresh, torso_fresh;
  result_t              track;
  int unsigned          mismatches;
  int unsigned          pending;
  int unsigned          send_max = 0;
  int unsigned          recv_max = 0;
  int unsigned          holds_asked = 0;
  int unsigned          idle_cycles;

  assign track = {track_valid, track_number, est_center_x, est_center_y, est_width,
                  est_height, est_shoulder, est_torso, shoulder_fresh, torso_fresh};

  detection_ema_tracker DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .detected      (frame.detected),
    .shoulder_ok   (frame.shoulder_ok),
    .torso_ok      (frame.torso_ok),
    .box_center_x  (frame.box_center_x),
    .box_center_y  (frame.box_center_y),
    .box_width     (frame.box_width),
    .box_height    (frame.box_height),
    .shoulder_span (frame.shoulder_span),
    .torso_span    (frame.torso_span),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .track_valid   (track_valid),
    .track_number  (track_number),
    .est_center_x  (est_center_x),
    .est_center_y  (est_center_y),
    .est_width     (est_width),
    .est_height    (est_height),
    .est_shoulder  (est_shoulder),
    .est_torso     (est_torso),
    .shoulder_fresh(shoulder_fresh),
    .torso_fresh   (torso_fresh)
  );

  detection_ema_tracker_check u_check (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .frame     (frame),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .track     (track),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic meas_t random_measure();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      default: return meas_t'($urandom);
    endcase
  endfunction

  // Mostly long detection runs broken by an occasional lost frame.
  function automatic item_t random_frame();
    item_t f;
    f.detected = ($urandom_range(11, 0) != 0);
    f.shoulder_ok = ($urandom_range(3, 0) != 0);
    f.torso_ok = ($urandom_range(3, 0) != 0);
    f.box_center_x = random_measure();
    f.box_center_y = random_measure();
    f.box_width = random_measure();
    f.box_height = random_measure();
    f.shoulder_span = random_measure();
    f.torso_span = random_measure();
    return f;
  endfunction

  task automatic drive_item(input item_t f);
    int unsigned gap;
    gap = $urandom_range(send_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    frame <= f;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_tracks();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_smoothing_weight(input logic [WeightWidth-1:0] w);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WeightAddr;
    pwdata <= DataWidth'(w);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    item_t                  probes[$];
    logic [WeightWidth-1:0] weights[NumPhases];
    int unsigned            send_lims[NumPhases];
    int unsigned            recv_lims[NumPhases];
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    frame <= '0;
    weights = '{9'd154, 9'd0, 9'd256, 9'd511, 9'd1, 9'd255, 9'd300, 9'd0};
    weights[NumPhases-1] = 9'($urandom_range(511, 0));
    send_lims = '{18, 0, 0, 18, 3, 18, 0, 9};
    recv_lims = '{0, 18, 0, 18, 3, 0, 9, 18};

    // Lost frame before any track, acquisition with no groups, each group seeding
    // alone and together, extremes of every measure and repeated lost frames.
    probes.push_back(item_t'({3'b011, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    probes.push_back(item_t'({3'b100, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    probes.push_back(item_t'({3'b110, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}));
    probes.push_back(item_t'({3'b111, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}));
    probes.push_back(item_t'({3'b111, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}));
    probes.push_back(item_t'({3'b100, 16'h8000, 16'h7FFF, 16'h1234, 16'h4321, 16'hABCD, 16'hDCBA}));
    probes.push_back(item_t'({3'b000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}));
    probes.push_back(item_t'({3'b011, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666}));
    probes.push_back(item_t'({3'b101, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}));
    probes.push_back(item_t'({3'b111, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}));
    probes.push_back(item_t'({3'b110, 16'h0001, 16'hFFFE, 16'h0001, 16'hFFFE, 16'h0001, 16'hFFFE}));
    probes.push_back(item_t'({3'b101, 16'hFFFE, 16'h0001, 16'hFFFE, 16'h0001, 16'hFFFE, 16'h0001}));
    probes.push_back(item_t'({3'b000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    probes.push_back(item_t'({3'b111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    probes.push_back(item_t'({3'b111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    probes.push_back(item_t'({3'b111, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain_tracks();
        set_smoothing_weight(weights[p]);
      end
      send_max = send_lims[p];
      recv_max = recv_lims[p];
      if (p == 0)
        foreach (probes[i]) drive_item(probes[i]);
      for (int n = 0; n < PhaseItems; n++) begin
        // The receiver holds off while items keep coming, so the block backs up.
        if (p == 2 && n == 20)
          holds_asked++;
        if (p == 3 && n == PhaseItems / 2)
          drain_tracks();
        drive_item(random_frame());
      end
    end

    drain_tracks();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("detection_ema_tracker: match");
    end else begin
      $display("detection_ema_tracker: mismatch");
    end
    $finish;
  end

  initial begin
    int unsigned holds_done;
    int unsigned pause;
    holds_done = 0;
    out_stall <= 1'b1;
    do @(posedge clk); while (rst);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      pause = $urandom_range(recv_max, 0);
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("detection_ema_tracker: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* files.f */
hw/rtl/dtrk_pkg.sv
hw/rtl/dtrk_ema_lane.sv
hw/rtl/dtrk_cfg.sv
hw/rtl/dtrk_update.sv
hw/rtl/detection_ema_tracker.sv
hw/rtl/dtrk_checker.sv
tb/detection_ema_tracker_check.sv
tb/detection_ema_tracker_test.sv
